// ===== rtl/fpcp_pkg.sv =====
// Package for the fixed prefix code packer: code ROM, field widths,
// controller state type and controller/datapath command and status structs.
// No dependencies.
package fpcp_pkg;

  localparam int unsigned RomDepth  = 257;
  localparam int unsigned IdxW      = 9;
  localparam int unsigned AccW      = 18;
  localparam int unsigned CntW      = 5;
  localparam int unsigned CodeW     = 12;
  localparam int unsigned LenW      = 4;
  localparam logic        KindData  = 1'b0;
  localparam logic        KindEnd   = 1'b1;
  localparam logic [IdxW-1:0] EndIdx = 9'd256;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } fpcp_state_t;

  typedef struct packed {
    logic load;
    logic emit_full;
    logic emit_pad;
  } fpcp_cmd_t;

  typedef struct packed {
    logic full;
    logic full_ends;
    logic rem;
    logic is_end;
    logic out_free;
  } fpcp_status_t;

  localparam logic [15:0] CODE_ROM [RomDepth] = '{
    16'h0002, 16'h01f5, 16'h0226, 16'h0347, 16'h0757, 16'h0286, 16'h03b6, 16'h0327,
    16'h0e08, 16'h0628, 16'h0567, 16'h0798, 16'h19d9, 16'h0978, 16'h02a6, 16'h0577,
    16'h0718, 16'h05b8, 16'h1cc9, 16'h0a78, 16'h0257, 16'h04f7, 16'h0668, 16'h07d8,
    16'h1919, 16'h1ce9, 16'h03f7, 16'h0909, 16'h0598, 16'h07b8, 16'h0918, 16'h0c68,
    16'h02d6, 16'h1869, 16'h06f8, 16'h0939, 16'h1cca, 16'h05a8, 16'h1aea, 16'h1c0a,
    16'h1489, 16'h14a9, 16'h0829, 16'h19fa, 16'h1719, 16'h1209, 16'h0e79, 16'h1f3a,
    16'h14b9, 16'h1009, 16'h1909, 16'h0136, 16'h1619, 16'h1259, 16'h1339, 16'h1959,
    16'h1739, 16'h1ca9, 16'h0869, 16'h1e99, 16'h0db9, 16'h1ec9, 16'h08b9, 16'h0859,
    16'h00a5, 16'h0968, 16'h09c8, 16'h1c39, 16'h19c9, 16'h08f9, 16'h18f9, 16'h0919,
    16'h0879, 16'h0c69, 16'h1779, 16'h0899, 16'h0d69, 16'h08c9, 16'h1ee9, 16'h1eb9,
    16'h0849, 16'h1649, 16'h1759, 16'h1cd9, 16'h05e8, 16'h0889, 16'h12b9, 16'h1729,
    16'h10a9, 16'h08d9, 16'h13a9, 16'h11c9, 16'h1e1a, 16'h1e0a, 16'h1879, 16'h1dca,
    16'h1dfa, 16'h0747, 16'h19f9, 16'h08d8, 16'h0e48, 16'h0797, 16'h0ea9, 16'h0e19,
    16'h0408, 16'h0417, 16'h10b9, 16'h0b09, 16'h06a8, 16'h0c18, 16'h0717, 16'h0787,
    16'h0b18, 16'h14c9, 16'h0437, 16'h0768, 16'h0667, 16'h04d7, 16'h08a9, 16'h02f6,
    16'h0c98, 16'h0ce9, 16'h1499, 16'h1609, 16'h1baa, 16'h19ea, 16'h39fa, 16'h0e59,
    16'h1949, 16'h1849, 16'h1269, 16'h0307, 16'h06c8, 16'h1219, 16'h1e89, 16'h1c1a,
    16'h11da, 16'h163a, 16'h385a, 16'h3dba, 16'h17da, 16'h106a, 16'h397a, 16'h24ea,
    16'h02e7, 16'h0988, 16'h33ca, 16'h32ea, 16'h1e9a, 16'h0bf9, 16'h3dfa, 16'h1dda,
    16'h32da, 16'h2eda, 16'h30ba, 16'h107a, 16'h2e8a, 16'h3dea, 16'h125a, 16'h1e8a,
    16'h0e99, 16'h1cda, 16'h1b5a, 16'h1659, 16'h232a, 16'h2e1a, 16'h3aeb, 16'h3c6b,
    16'h3e2b, 16'h205a, 16'h29aa, 16'h248a, 16'h2cda, 16'h23ba, 16'h3c5b, 16'h251a,
    16'h2e9a, 16'h252a, 16'h1ea9, 16'h3a0b, 16'h391b, 16'h23ca, 16'h392b, 16'h3d5b,
    16'h233a, 16'h2cca, 16'h390b, 16'h1bba, 16'h3a1b, 16'h3c4b, 16'h211a, 16'h203a,
    16'h12a9, 16'h231a, 16'h3e0b, 16'h29ba, 16'h3d7b, 16'h202a, 16'h3adb, 16'h213a,
    16'h253a, 16'h32ca, 16'h23da, 16'h23fa, 16'h32fa, 16'h11ca, 16'h384a, 16'h31ca,
    16'h17ca, 16'h30aa, 16'h2e0a, 16'h276a, 16'h250a, 16'h3e3b, 16'h396a, 16'h18fa,
    16'h204a, 16'h206a, 16'h230a, 16'h265a, 16'h212a, 16'h23ea, 16'h3acb, 16'h393b,
    16'h3e1b, 16'h1dea, 16'h3d6b, 16'h31da, 16'h3e5b, 16'h3e4b, 16'h207a, 16'h3c7b,
    16'h277a, 16'h3d4b, 16'h0c08, 16'h162a, 16'h3daa, 16'h124a, 16'h1b4a, 16'h264a,
    16'h33da, 16'h1d1a, 16'h1afa, 16'h39ea, 16'h24fa, 16'h373b, 16'h249a, 16'h372b,
    16'h1679, 16'h210a, 16'h23aa, 16'h1b8a, 16'h3afb, 16'h18ea, 16'h2eca, 16'h0627,
    16'h00d4
  };

endpackage

// ===== rtl/fpcp_ctrl.sv =====
// Controller for the fixed prefix code packer: sequences load and byte emission.
// Depends on fpcp_pkg; drives the datapath fpcp_dp by command struct.
module fpcp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpcp_pkg::fpcp_status_t status,
  output fpcp_pkg::fpcp_cmd_t    cmd
);
  import fpcp_pkg::*;

  fpcp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (status.full) begin
          if (status.out_free && status.full_ends) begin
            state_nxt = ST_IDLE;
          end
        end else if (status.is_end && status.rem) begin
          if (status.out_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WORK: begin
        cmd.emit_full = status.full && status.out_free;
        cmd.emit_pad  = !status.full && status.is_end && status.rem && status.out_free;
      end
      default: ;
    endcase
  end

  a_pad_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pad |-> status.is_end)
    else $error("pad byte emitted for a data item");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WORK) |-> !cmd.load)
    else $error("load while work pending");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_full && cmd.emit_pad))
    else $error("two emits in one cycle");

endmodule

// ===== rtl/fpcp_dp.sv =====
// Datapath for the fixed prefix code packer: ROM lookup, bit accumulator,
// output register. Depends on fpcp_pkg; commanded by fpcp_ctrl.
module fpcp_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_kind,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  input  fpcp_pkg::fpcp_cmd_t    cmd,
  output fpcp_pkg::fpcp_status_t status
);
  import fpcp_pkg::*;

  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             kind_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [IdxW-1:0]  idx;
  logic [15:0]      word;
  logic [LenW-1:0]  len;
  logic [CodeW-1:0] code;
  logic [AccW-1:0]  pend;
  logic [CntW-1:0]  cnt_sub;
  logic [AccW-1:0]  full_shift;
  logic [AccW-1:0]  pad_shift;

  always_comb begin
    idx        = (in_kind == KindEnd) ? EndIdx : {1'b0, in_data_byte};
    word       = CODE_ROM[idx];
    len        = word[3:0];
    code       = word[15:4] & ((CodeW'(1) << len) - CodeW'(1));
    pend       = acc_r & ((AccW'(1) << cnt_r) - AccW'(1));
    cnt_sub    = cnt_r - CntW'(8);
    full_shift = acc_r >> cnt_sub;
    pad_shift  = acc_r << (CntW'(8) - cnt_r);
  end

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      acc_nxt = (pend << len) | {{(AccW-CodeW){1'b0}}, code};
      cnt_nxt = cnt_r + {1'b0, len};
    end else if (cmd.emit_full) begin
      cnt_nxt = cnt_sub;
    end else if (cmd.emit_pad) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      if (cmd.emit_full || cmd.emit_pad) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
    end
    if (cmd.emit_full) begin
      out_byte_r <= full_shift[7:0];
      out_last_r <= (kind_r == KindEnd) && (cnt_r == CntW'(8));
    end else if (cmd.emit_pad) begin
      out_byte_r <= pad_shift[7:0];
      out_last_r <= 1'b1;
    end
  end

  always_comb begin
    status.full      = (cnt_r >= CntW'(8));
    status.full_ends = (kind_r == KindEnd) ? (cnt_r == CntW'(8)) : (cnt_r < CntW'(16));
    status.rem       = (cnt_r != '0);
    status.is_end    = (kind_r == KindEnd);
    status.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(18))
    else $error("accumulator count out of range");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_full || cmd.emit_pad) |=> out_valid_r)
    else $error("emitted byte not presented");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_full || cmd.emit_pad) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_pad |=> (cnt_r == '0))
    else $error("accumulator not cleared after packet end");

endmodule

// ===== rtl/fixed_prefix_code_packer.sv =====
// Top level of the fixed prefix code packer: controller plus datapath.
// Depends on fpcp_pkg, fpcp_ctrl and fpcp_dp.
//
//   channel  | ports                                | direction
//   in       | in_valid in_ready in_kind in_data_byte | item in
//   out      | out_valid out_ready out_byte out_last  | byte out
//
// An item is taken in the idle state; the work state then emits each
// completed byte, plus a padded last byte at a packet end, and is entered
// even when no byte completes; no item is taken until it ends. The single
// output register drains the accumulator one byte a cycle unless stalled.
// Reset is synchronous, active low, and empties the accumulator.
// A stalled output register holds its byte and pauses byte emission.
module fixed_prefix_code_packer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import fpcp_pkg::*;

  fpcp_cmd_t    cmd;
  fpcp_status_t status;

  fpcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpcp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
